// File: design/rsks_pkg.sv
// Shared constants, types and tables for the rectifier soft-knee shaper.
`default_nettype none
package rsks_pkg;

   localparam int CORDIC_STAGES_DEF = 16;
   localparam int SAMPLE_BITS_DEF   = 16;

   localparam int ATAN_ENTRIES = 24;
   localparam int PRESHIFT     = 8;
   localparam int Z_W          = 32;
   localparam int DROP_W       = 17;
   localparam int SOFT_W       = 23;
   localparam int SZ_W         = SOFT_W + 1 + Z_W;
   localparam int GAIN_W       = 20;
   localparam int Q_SHIFT      = 30;
   localparam int CSR_INDEX_W  = 1;
   localparam int CSR_DATA_W   = SOFT_W;

   localparam logic [DROP_W-1:0] DROP_FULL   = 17'd65536;
   localparam logic [DROP_W-1:0] DROP_RESET  = 17'd0;
   localparam logic [SOFT_W-1:0] SOFT_RESET  = 23'd32768;
   localparam logic [SOFT_W-1:0] SOFT_MIN    = 23'd1;
   localparam logic [GAIN_W-1:0] INV_GAIN_Q20 = 20'd636751;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_DROP = 1'b0,
      CSR_SOFT = 1'b1
   } csr_index_type;

   // atan(2^-i) in Q2.30, rounded to nearest
   localparam logic [Z_W-1:0] ATAN_Q30 [ATAN_ENTRIES] = '{
      32'd843314857, 32'd497837829, 32'd263043837, 32'd133525159,
      32'd67021687,  32'd33543516,  32'd16775851,  32'd8388437,
      32'd4194283,   32'd2097149,   32'd1048576,   32'd524288,
      32'd262144,    32'd131072,    32'd65536,     32'd32768,
      32'd16384,     32'd8192,      32'd4096,      32'd2048,
      32'd1024,      32'd512,       32'd256,       32'd128
   };

endpackage
`default_nettype wire

// File: design/rsks_front.sv
// Front end: full-wave rectification, drop scaling and CORDIC vector set-up.
`default_nettype none
module rsks_front
   import rsks_pkg::*;
#(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
   parameter int CW          = 34
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          in_valid,
   input  wire logic signed [SAMPLE_BITS-1:0] sample,
   input  wire logic        [DROP_W-1:0]      drop,
   input  wire logic        [SOFT_W-1:0]      softness,
   output logic                               out_valid,
   output logic             [SAMPLE_BITS-1:0] x,
   output logic signed      [CW-1:0]          cx,
   output logic signed      [CW-1:0]          cy
);

   localparam int PW = SAMPLE_BITS + DROP_W;

   logic                   v1_ff, v1_in;
   logic [PW-1:0]          prod_ff, prod_in;
   logic                   v2_ff, v2_in;
   logic [SAMPLE_BITS-1:0] x_ff, x_in;
   logic [SAMPLE_BITS-1:0] mag;
   logic [DROP_W-1:0]      keep;
   logic [PW:0]            rounded;

   always_comb begin
      mag     = sample[SAMPLE_BITS-1] ? (~sample + 1'b1) : sample;
      keep    = DROP_FULL - drop;
      prod_in = PW'(mag) * PW'(keep);
      v1_in   = in_valid;
      rounded = {1'b0, prod_ff} + (PW+1)'(32768);
      x_in    = rounded[SAMPLE_BITS+15:16];
      v2_in   = v1_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
      end
      prod_ff <= prod_in;
      x_ff    <= x_in;
   end

   assign out_valid = v2_ff;
   assign x         = x_ff;
   assign cx        = $signed(CW'(softness) << PRESHIFT);
   assign cy        = $signed(CW'(x_ff) << PRESHIFT);

endmodule
`default_nettype wire

// File: design/rsks_cordic_stage.sv
// One registered CORDIC vectoring iteration.
`default_nettype none
module rsks_cordic_stage
   import rsks_pkg::*;
#(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
   parameter int CW          = 34,
   parameter int STAGE       = 0
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          in_valid,
   input  wire logic        [SAMPLE_BITS-1:0] in_x,
   input  wire logic signed [CW-1:0]          in_cx,
   input  wire logic signed [CW-1:0]          in_cy,
   input  wire logic signed [Z_W-1:0]         in_z,
   output logic                               out_valid,
   output logic             [SAMPLE_BITS-1:0] out_x,
   output logic signed      [CW-1:0]          out_cx,
   output logic signed      [CW-1:0]          out_cy,
   output logic signed      [Z_W-1:0]         out_z
);

   localparam logic signed [Z_W-1:0] ANGLE = $signed(ATAN_Q30[STAGE]);

   logic                    valid_ff, valid_in;
   logic [SAMPLE_BITS-1:0]  x_ff, x_in;
   logic signed [CW-1:0]    cx_ff, cx_in;
   logic signed [CW-1:0]    cy_ff, cy_in;
   logic signed [Z_W-1:0]   z_ff, z_in;
   logic signed [CW-1:0]    dx;
   logic signed [CW-1:0]    dy;

   always_comb begin
      dx       = in_cy >>> STAGE;
      dy       = in_cx >>> STAGE;
      valid_in = in_valid;
      x_in     = in_x;
      if (!in_cy[CW-1]) begin
         cx_in = in_cx + dx;
         cy_in = in_cy - dy;
         z_in  = in_z + ANGLE;
      end else begin
         cx_in = in_cx - dx;
         cy_in = in_cy + dy;
         z_in  = in_z - ANGLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      x_ff  <= x_in;
      cx_ff <= cx_in;
      cy_ff <= cy_in;
      z_ff  <= z_in;
   end

   assign out_valid = valid_ff;
   assign out_x     = x_ff;
   assign out_cx    = cx_ff;
   assign out_cy    = cy_ff;
   assign out_z     = z_ff;

endmodule
`default_nettype wire

// File: design/rsks_back.sv
// Back end: angle scaling, residual correction, rounding and limit to x.
`default_nettype none
module rsks_back
   import rsks_pkg::*;
#(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
   parameter int CW          = 34
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          in_valid,
   input  wire logic        [SAMPLE_BITS-1:0] in_x,
   input  wire logic signed [CW-1:0]          in_cy,
   input  wire logic signed [Z_W-1:0]         in_z,
   input  wire logic        [SOFT_W-1:0]      softness,
   output logic                               out_strobe,
   output logic             [SAMPLE_BITS-1:0] out_sample
);

   localparam int YW = CW + GAIN_W + 1;
   localparam int VW = ((SZ_W > YW + 2) ? SZ_W : YW + 2) + 1;
   localparam logic [VW-1:0] HALF_LSB = {{(VW-Q_SHIFT){1'b0}}, 1'b1, {(Q_SHIFT-1){1'b0}}};

   logic                    m_valid_ff, m_valid_in;
   logic [SAMPLE_BITS-1:0]  m_x_ff, m_x_in;
   logic signed [SZ_W-1:0]  sz_ff, sz_in;
   logic signed [YW-1:0]    yg_ff, yg_in;
   logic                    s_valid_ff, s_valid_in;
   logic [SAMPLE_BITS-1:0]  s_x_ff, s_x_in;
   logic signed [VW-1:0]    v_ff, v_in;
   logic                    o_valid_ff, o_valid_in;
   logic [SAMPLE_BITS-1:0]  o_res_ff, o_res_in;
   logic signed [YW+1:0]    yg4;
   logic [VW-1:0]           r_full;
   logic [VW-1:0]           x_ext;

   always_comb begin
      m_valid_in = in_valid;
      m_x_in     = in_x;
      sz_in      = $signed({1'b0, softness}) * in_z;
      yg_in      = in_cy * $signed({1'b0, INV_GAIN_Q20});

      yg4        = $signed({yg_ff, 2'b00});
      s_valid_in = m_valid_ff;
      s_x_in     = m_x_ff;
      v_in       = VW'(sz_ff) + VW'(yg4);

      o_valid_in = s_valid_ff;
      r_full     = (v_ff[VW-1]) ? '0 : ((VW'(v_ff) + HALF_LSB) >> Q_SHIFT);
      x_ext      = VW'(s_x_ff);
      o_res_in   = (r_full > x_ext) ? s_x_ff : r_full[SAMPLE_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m_valid_ff <= 1'b0;
         s_valid_ff <= 1'b0;
         o_valid_ff <= 1'b0;
      end else begin
         m_valid_ff <= m_valid_in;
         s_valid_ff <= s_valid_in;
         o_valid_ff <= o_valid_in;
      end
      m_x_ff   <= m_x_in;
      sz_ff    <= sz_in;
      yg_ff    <= yg_in;
      s_x_ff   <= s_x_in;
      v_ff     <= v_in;
      o_res_ff <= o_res_in;
   end

   assign out_strobe = o_valid_ff;
   assign out_sample = o_res_ff;

endmodule
`default_nettype wire

// File: design/rectifier_soft_knee_shaper_top.sv
// Top level of the rectifier soft-knee shaper: registers and pipeline.
//
//   channel   ports                                   handshake
//   request   start, busy, req_sample_in              start & !busy
//   response  rsp_strobe, rsp_sample_out              rsp_strobe, one cycle
//   csr       csr_write_enable, csr_index, csr_write_data   write enable
//
// Pipeline: 2 front registers, one per CORDIC iteration (CORDIC_STAGES, at most 24),
// 3 back; one transaction per cycle, busy is always low.
// The pipeline depth grows with the CORDIC chain, one iteration a stage; width is CW.
// Reset clears the valid bits and loads drop 0 and softness 32768.
// No stalls: each result is shown for one cycle and must be taken.
`default_nettype none
module rectifier_soft_knee_shaper_top
   import rsks_pkg::*;
#(
   parameter int CORDIC_STAGES = CORDIC_STAGES_DEF,
   parameter int SAMPLE_BITS   = SAMPLE_BITS_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic signed [SAMPLE_BITS-1:0] req_sample_in,
   output logic                               rsp_strobe,
   output logic             [SAMPLE_BITS-1:0] rsp_sample_out,
   input  wire logic                          csr_write_enable,
   input  wire logic        [CSR_INDEX_W-1:0] csr_index,
   input  wire logic        [CSR_DATA_W-1:0]  csr_write_data
);

   localparam int NSTAGES = (CORDIC_STAGES < ATAN_ENTRIES) ? CORDIC_STAGES : ATAN_ENTRIES;
   localparam int MAXW    = (SAMPLE_BITS > SOFT_W) ? SAMPLE_BITS : SOFT_W;
   localparam int CW      = MAXW + PRESHIFT + 3;

   logic [DROP_W-1:0] drop_ff, drop_in;
   logic [SOFT_W-1:0] soft_ff, soft_in;
   logic [DROP_W-1:0] wr_drop;
   logic [SOFT_W-1:0] wr_soft;

   logic                    c_valid [NSTAGES+1];
   logic [SAMPLE_BITS-1:0]  c_x     [NSTAGES+1];
   logic signed [CW-1:0]    c_cx    [NSTAGES+1];
   logic signed [CW-1:0]    c_cy    [NSTAGES+1];
   logic signed [Z_W-1:0]   c_z     [NSTAGES+1];

   // register writes saturate on the way in
   always_comb begin
      wr_drop = csr_write_data[DROP_W-1:0];
      if (wr_drop > DROP_FULL) begin
         wr_drop = DROP_FULL;
      end
      wr_soft = csr_write_data[SOFT_W-1:0];
      if (wr_soft == '0) begin
         wr_soft = SOFT_MIN;
      end
      drop_in = drop_ff;
      soft_in = soft_ff;
      if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            CSR_DROP: drop_in = wr_drop;
            CSR_SOFT: soft_in = wr_soft;
            default:  drop_in = drop_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         drop_ff <= DROP_RESET;
         soft_ff <= SOFT_RESET;
      end else begin
         drop_ff <= drop_in;
         soft_ff <= soft_in;
      end
   end

   assign busy = 1'b0;

   rsks_front #(
      .SAMPLE_BITS(SAMPLE_BITS),
      .CW(CW)
   ) u_front (
      .clock(clock),
      .reset(reset),
      .in_valid(start & ~busy),
      .sample(req_sample_in),
      .drop(drop_ff),
      .softness(soft_ff),
      .out_valid(c_valid[0]),
      .x(c_x[0]),
      .cx(c_cx[0]),
      .cy(c_cy[0])
   );

   assign c_z[0] = '0;

   for (genvar i = 0; i < NSTAGES; i++) begin : g_cordic
      rsks_cordic_stage #(
         .SAMPLE_BITS(SAMPLE_BITS),
         .CW(CW),
         .STAGE(i)
      ) u_stage (
         .clock(clock),
         .reset(reset),
         .in_valid(c_valid[i]),
         .in_x(c_x[i]),
         .in_cx(c_cx[i]),
         .in_cy(c_cy[i]),
         .in_z(c_z[i]),
         .out_valid(c_valid[i+1]),
         .out_x(c_x[i+1]),
         .out_cx(c_cx[i+1]),
         .out_cy(c_cy[i+1]),
         .out_z(c_z[i+1])
      );
   end

   rsks_back #(
      .SAMPLE_BITS(SAMPLE_BITS),
      .CW(CW)
   ) u_back (
      .clock(clock),
      .reset(reset),
      .in_valid(c_valid[NSTAGES]),
      .in_x(c_x[NSTAGES]),
      .in_cy(c_cy[NSTAGES]),
      .in_z(c_z[NSTAGES]),
      .softness(soft_ff),
      .out_strobe(rsp_strobe),
      .out_sample(rsp_sample_out)
   );

endmodule
`default_nettype wire

// File: sim/tb.sv
// Testbench for the rectifier soft-knee shaper: directed and random samples, checked in order.
`timescale 1ns / 1ps
module tb;
   import rsks_pkg::*;

   localparam int STAGES        = CORDIC_STAGES_DEF;
   localparam int SBITS         = SAMPLE_BITS_DEF;
   localparam int LATENCY       = STAGES + 5;
   localparam int CYCLE_LIMIT   = 200000;
   localparam int RANDOM_PHASES = 12;
   localparam int PHASE_ITEMS   = 110;
   localparam int VEC_SHIFT     = 8;
   localparam int ROUND_SHIFT   = 30;
   localparam longint RECIP_GAIN = 636751;
   localparam longint ANGLE_STEP [24] = '{
      843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
      16775851, 8388437, 4194283, 2097149, 1048576, 524288,
      262144, 131072, 65536, 32768, 16384, 8192,
      4096, 2048, 1024, 512, 256, 128
   };

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    start = 1'b0;
   logic                    busy;
   logic signed [SBITS-1:0] req_sample_in = '0;
   logic                    rsp_strobe;
   logic        [SBITS-1:0] rsp_sample_out;
   logic                    csr_write_enable = 1'b0;
   logic  [CSR_INDEX_W-1:0] csr_index = '0;
   logic   [CSR_DATA_W-1:0] csr_write_data = '0;

   logic signed [SBITS-1:0] sample_backlog [$];
   logic        [SBITS-1:0] knee_out_q [$];
   logic        [SBITS-1:0] want_out;
   logic       [DROP_W-1:0] drop_cfg = DROP_RESET;
   logic       [SOFT_W-1:0] soft_cfg = SOFT_RESET;
   int                      send_idle_pct = 0;
   int                      mismatches = 0;
   int                      cycle_count = 0;

   rectifier_soft_knee_shaper_top #(
      .CORDIC_STAGES(STAGES),
      .SAMPLE_BITS  (SBITS)
   ) u_dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_sample_in   (req_sample_in),
      .rsp_strobe      (rsp_strobe),
      .rsp_sample_out  (rsp_sample_out),
      .csr_write_enable(csr_write_enable),
      .csr_index       (csr_index),
      .csr_write_data  (csr_write_data)
   );

   always #10 clock = ~clock;

   // rectify, apply drop, then s*atan(x/s) by vectoring CORDIC plus residual term
   function automatic logic [SBITS-1:0] soft_knee(logic signed [SBITS-1:0] smp,
                                                  logic [DROP_W-1:0] drop_reg,
                                                  logic [SOFT_W-1:0] soft_reg);
      longint mag, drop, s, x, cx, cy, z, dx, dy, v, res;
      mag = smp;
      if (mag < 0) mag = -mag;
      drop = (drop_reg > DROP_FULL) ? 65536 : drop_reg;
      s = (soft_reg == '0) ? 1 : soft_reg;
      x = (mag * (65536 - drop) + 32768) >>> 16;
      cx = s <<< VEC_SHIFT;
      cy = x <<< VEC_SHIFT;
      z = 0;
      for (int i = 0; i < STAGES && i < 24; i++) begin
         dx = cy >>> i;
         dy = cx >>> i;
         if (cy >= 0) begin
            cx = cx + dx;
            cy = cy - dy;
            z = z + ANGLE_STEP[i];
         end else begin
            cx = cx - dx;
            cy = cy + dy;
            z = z - ANGLE_STEP[i];
         end
      end
      v = s * z + cy * RECIP_GAIN * 4;
      if (v < 0) res = 0;
      else res = (v + (64'sd1 <<< (ROUND_SHIFT - 1))) >>> ROUND_SHIFT;
      if (res > x) res = x;
      return res[SBITS-1:0];
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) knee_out_q.push_back(soft_knee(req_sample_in, drop_cfg, soft_cfg));
         if (!start || !busy) begin
            if (sample_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               start <= 1'b1;
               req_sample_in <= sample_backlog.pop_front();
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (knee_out_q.size() == 0) begin
            $display("%0t: sample_out expected none, actual %0d", $time, rsp_sample_out);
            mismatches++;
         end else begin
            want_out = knee_out_q.pop_front();
            if (rsp_sample_out !== want_out) begin
               $display("%0t: sample_out expected %0d, actual %0d",
                        $time, want_out, rsp_sample_out);
               mismatches++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   task automatic drain();
      while (sample_backlog.size() != 0 || start || knee_out_q.size() != 0)
         @(negedge clock);
      repeat (LATENCY) @(negedge clock);
   endtask

   task automatic write_reg(csr_index_type idx, logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= data;
      case (idx)
         CSR_DROP: drop_cfg = data[DROP_W-1:0];
         CSR_SOFT: soft_cfg = data;
      endcase
      @(posedge clock);
      csr_write_enable <= 1'b0;
      @(negedge clock);
   endtask

   initial begin
      logic signed [SBITS-1:0] corner_samples [10];
      int idle_plan [4];
      int pick;
      logic [DROP_W-1:0] drop_val;
      logic [SOFT_W-1:0] soft_val;
      logic signed [SBITS-1:0] smp;

      corner_samples = '{16'sh0000, 16'sh0001, 16'shFFFF, 16'sh7FFF, 16'sh8000,
                         16'sh8001, 16'sh4000, 16'shC000, 16'sh5555, 16'shAAAA};
      idle_plan = '{0, 69, 0, 13};
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (corner_samples[i]) sample_backlog.push_back(corner_samples[i]);
      drain();

      // full drop, hardest knee
      write_reg(CSR_DROP, CSR_DATA_W'(65536));
      write_reg(CSR_SOFT, CSR_DATA_W'(1));
      sample_backlog = '{16'sh8000, 16'sh7FFF, 16'sh3039};
      drain();

      // drop above full (upper data bits masked off), zero softness
      write_reg(CSR_DROP, 23'h7F_FFFF);
      write_reg(CSR_SOFT, CSR_DATA_W'(0));
      sample_backlog = '{16'sh8000, 16'sh7FFF, 16'shFFFF};
      drop_val = '0;
      drain();

      write_reg(CSR_DROP, CSR_DATA_W'(0));
      write_reg(CSR_SOFT, 23'h7F_FFFF);
      sample_backlog = '{16'sh8000, 16'sh7FFF, 16'sh0001};
      drain();

      write_reg(CSR_DROP, CSR_DATA_W'(65535));
      write_reg(CSR_SOFT, CSR_DATA_W'(1));
      sample_backlog = '{16'sh8000, 16'sh7FFF, 16'shCFC7};
      drain();

      for (int k = 0; k < RANDOM_PHASES; k++) begin
         pick = $urandom_range(9);
         case (pick)
            0:       drop_val = '0;
            1:       drop_val = DROP_FULL;
            2:       drop_val = DROP_W'($urandom_range(131071, 65537));
            default: drop_val = DROP_W'($urandom_range(65536, 0));
         endcase
         write_reg(CSR_DROP, {6'($urandom_range(63)), drop_val});
         pick = $urandom_range(9);
         case (pick)
            0:       soft_val = SOFT_W'($urandom_range(1));
            1:       soft_val = 23'h7F_FFFF;
            2, 3:    soft_val = SOFT_W'($urandom_range(255, 2));
            4, 5:    soft_val = SOFT_W'($urandom_range(65535, 256));
            default: soft_val = SOFT_W'($urandom_range(8388607, 65536));
         endcase
         write_reg(CSR_SOFT, soft_val);
         send_idle_pct = idle_plan[k % 4];
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            pick = $urandom_range(19);
            if (pick == 0) begin
               case ($urandom_range(4))
                  0:       smp = 16'sh8000;
                  1:       smp = 16'sh7FFF;
                  2:       smp = 16'sh0000;
                  3:       smp = 16'sh0001;
                  default: smp = 16'shFFFF;
               endcase
            end else if (pick == 1) begin
               smp = SBITS'(int'($urandom_range(511)) - 256);
            end else begin
               smp = SBITS'($urandom);
            end
            sample_backlog.push_back(smp);
         end
         drain();
      end

      if (mismatches == 0 && knee_out_q.size() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
